FILE: hdl/ffsa_pkg.sv
// Shared types and constants of the first-fit segment allocator.
// Holds the controller command set, the datapath status flags and the result codes.
// No dependencies.
package ffsa_pkg;

    localparam int DEFAULT_MAX_SEGMENTS = 64;
    localparam int DEFAULT_ADDR_WIDTH   = 16;
    localparam int SIZE_W  = 17;   // request size and managed space size
    localparam int FADDR_W = 16;   // free_address
    localparam int GRANT_W = 16;   // granted_address
    localparam int STAT_W  = 2;

    // Result codes.
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOADDR = 2'd2;
    localparam logic [STAT_W-1:0] ST_UFULL  = 2'd3;

    localparam logic MODE_FREE = 1'b1;

    // Commands from the controller to the datapath, one per cycle.
    typedef enum logic [5:0] {
        CMD_NOP, CMD_LATCH, CMD_INC_I, CMD_INC_J,
        CMD_FRD_I, CMD_FRD_B, CMD_FRD_A, CMD_FRD_KP1, CMD_FRD_KM1,
        CMD_URD_J, CMD_URD_KM1, CMD_URD_KP1,
        CMD_CAP_F, CMD_CAP_B, CMD_CAP_U, CMD_CALC_LOC,
        CMD_UWR_K_DEC, CMD_UWR_NEW, CMD_UWR_K_INC, CMD_UE_INIT, CMD_UCNT_DEC,
        CMD_FSUB, CMD_FWR_K_INC, CMD_FWR_K_DEC, CMD_FCNT_DEC,
        CMD_SET_B, CMD_MERGE_A, CMD_GROW_B, CMD_MERGE_BA, CMD_WR_A, CMD_WR_B,
        CMD_INS_INIT, CMD_INS_NEW, CMD_RESULT, CMD_OUT_LOAD
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [STAT_W-1:0] status;   // result code that goes with CMD_RESULT
    } t_ctl;

    typedef struct packed {
        logic size_zero;
        logic mode_free;
        logic i_end;      // free scan index reached the free count
        logic fit;        // free entry just read is large enough
        logic u_full;
        logic j_end;      // used scan index reached the used count
        logic u_ge;       // used start just read is at or above the target
        logic u_eq;
        logic f_ge;       // free start just read is at or above the address
        logic k_eq_j;
        logic k_eq_a;
        logic a_end;      // entry above does not exist
        logic case_a;     // released segment touches the entry above
        logic case_b;     // released segment touches the entry below
        logic adj_ba;     // entry below touches entry above
        logic f_room;
        logic fe_last;
        logic ue_last;
        logic fl_erase;   // carved free entry emptied and may be removed
        logic out_free;
    } t_flags;

endpackage

FILE: hdl/ffsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

FILE: hdl/ffsa_ctrl.sv
// Controller of the segment allocator: sequences scans, shifts and merges.
// Depends on ffsa_pkg; drives the datapath through t_ctl and reads t_flags.
module ffsa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ffsa_pkg::t_flags i_flags,
    output ffsa_pkg::t_ctl   o_ctl
);
    import ffsa_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE, S_DISP,
        S_AF_RD, S_AF_CHK, S_A_FULL, S_AU_RD, S_AU_CHK, S_ASH_RD, S_ASH_WR,
        S_AU_WR, S_AF_UPD, S_A_ER,
        S_FU_RD, S_FU_CHK, S_FF_RD, S_FF_CHK, S_FB, S_FB_RD, S_FB_CAP,
        S_FA_RD, S_FA_CAP, S_FDEC, S_FA_M, S_FB_M, S_INS_RD, S_INS_SH, S_INS_WR,
        S_E_RD, S_E_WR, S_E_END, S_UE_INIT, S_UE_RD, S_UE_WR, S_UE_END,
        S_OK, S_DONE
    } t_state;

    t_state r_state, n_state;
    t_ctl   w_ctl;

    // Next state and command for the current cycle.
    always_comb begin
        n_state      = r_state;
        w_ctl.cmd    = CMD_NOP;
        w_ctl.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_ctl.cmd = CMD_LATCH;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                if (i_flags.mode_free) begin
                    n_state = S_FU_RD;
                end else if (i_flags.size_zero) begin
                    w_ctl.cmd = CMD_RESULT; w_ctl.status = ST_NOFIT; n_state = S_DONE;
                end else begin
                    n_state = S_AF_RD;
                end
            end
            // Allocate: first-fit scan of the free table.
            S_AF_RD: begin
                if (i_flags.i_end) begin
                    w_ctl.cmd = CMD_RESULT; w_ctl.status = ST_NOFIT; n_state = S_DONE;
                end else begin
                    w_ctl.cmd = CMD_FRD_I; n_state = S_AF_CHK;
                end
            end
            S_AF_CHK: begin
                if (i_flags.fit) begin
                    w_ctl.cmd = CMD_CAP_F; n_state = S_A_FULL;
                end else begin
                    w_ctl.cmd = CMD_INC_I; n_state = S_AF_RD;
                end
            end
            S_A_FULL: begin
                if (i_flags.u_full) begin
                    w_ctl.cmd = CMD_RESULT; w_ctl.status = ST_UFULL; n_state = S_DONE;
                end else begin
                    w_ctl.cmd = CMD_CALC_LOC; n_state = S_AU_RD;
                end
            end
            // Allocate: find the insertion place in the used table.
            S_AU_RD: begin
                if (i_flags.j_end) begin
                    n_state = S_ASH_RD;
                end else begin
                    w_ctl.cmd = CMD_URD_J; n_state = S_AU_CHK;
                end
            end
            S_AU_CHK: begin
                if (i_flags.u_ge) begin
                    n_state = S_ASH_RD;
                end else begin
                    w_ctl.cmd = CMD_INC_J; n_state = S_AU_RD;
                end
            end
            S_ASH_RD: begin
                if (i_flags.k_eq_j) begin
                    n_state = S_AU_WR;
                end else begin
                    w_ctl.cmd = CMD_URD_KM1; n_state = S_ASH_WR;
                end
            end
            S_ASH_WR: begin
                w_ctl.cmd = CMD_UWR_K_DEC; n_state = S_ASH_RD;
            end
            S_AU_WR: begin
                w_ctl.cmd = CMD_UWR_NEW; n_state = S_AF_UPD;
            end
            S_AF_UPD: begin
                w_ctl.cmd = CMD_FSUB; n_state = S_A_ER;
            end
            S_A_ER: begin
                n_state = i_flags.fl_erase ? S_E_RD : S_OK;
            end
            // Free: exact lookup in the used table.
            S_FU_RD: begin
                if (i_flags.j_end) begin
                    w_ctl.cmd = CMD_RESULT; w_ctl.status = ST_NOADDR; n_state = S_DONE;
                end else begin
                    w_ctl.cmd = CMD_URD_J; n_state = S_FU_CHK;
                end
            end
            S_FU_CHK: begin
                if (i_flags.u_ge) begin
                    if (i_flags.u_eq) begin
                        w_ctl.cmd = CMD_CAP_U; n_state = S_FF_RD;
                    end else begin
                        w_ctl.cmd = CMD_RESULT; w_ctl.status = ST_NOADDR; n_state = S_DONE;
                    end
                end else begin
                    w_ctl.cmd = CMD_INC_J; n_state = S_FU_RD;
                end
            end
            // Free: locate the free neighbours.
            S_FF_RD: begin
                if (i_flags.i_end) begin
                    n_state = S_FB;
                end else begin
                    w_ctl.cmd = CMD_FRD_I; n_state = S_FF_CHK;
                end
            end
            S_FF_CHK: begin
                if (i_flags.f_ge) begin
                    n_state = S_FB;
                end else begin
                    w_ctl.cmd = CMD_INC_I; n_state = S_FF_RD;
                end
            end
            S_FB:     begin w_ctl.cmd = CMD_SET_B; n_state = S_FB_RD;  end
            S_FB_RD:  begin w_ctl.cmd = CMD_FRD_B; n_state = S_FB_CAP; end
            S_FB_CAP: begin w_ctl.cmd = CMD_CAP_B; n_state = S_FA_RD;  end
            S_FA_RD: begin
                if (i_flags.a_end) begin
                    n_state = S_FDEC;
                end else begin
                    w_ctl.cmd = CMD_FRD_A; n_state = S_FA_CAP;
                end
            end
            S_FA_CAP: begin w_ctl.cmd = CMD_CAP_F; n_state = S_FDEC; end
            // Free: merge or insert.
            S_FDEC: begin
                if (i_flags.case_a) begin
                    w_ctl.cmd = CMD_MERGE_A; n_state = S_FA_M;
                end else if (i_flags.case_b) begin
                    w_ctl.cmd = CMD_GROW_B; n_state = S_FB_M;
                end else if (i_flags.f_room) begin
                    w_ctl.cmd = CMD_INS_INIT; n_state = S_INS_RD;
                end else begin
                    n_state = S_UE_INIT;
                end
            end
            S_FA_M: begin
                if (i_flags.adj_ba) begin
                    w_ctl.cmd = CMD_MERGE_BA; n_state = S_E_RD;
                end else begin
                    w_ctl.cmd = CMD_WR_A; n_state = S_UE_INIT;
                end
            end
            S_FB_M: begin
                if (i_flags.adj_ba && !i_flags.a_end) begin
                    w_ctl.cmd = CMD_MERGE_BA; n_state = S_E_RD;
                end else begin
                    w_ctl.cmd = CMD_WR_B; n_state = S_UE_INIT;
                end
            end
            S_INS_RD: begin
                if (i_flags.k_eq_a) begin
                    n_state = S_INS_WR;
                end else begin
                    w_ctl.cmd = CMD_FRD_KM1; n_state = S_INS_SH;
                end
            end
            S_INS_SH: begin w_ctl.cmd = CMD_FWR_K_DEC; n_state = S_INS_RD;    end
            S_INS_WR: begin w_ctl.cmd = CMD_INS_NEW;   n_state = S_UE_INIT;   end
            // Free-table erase, shared by both requests.
            S_E_RD: begin
                if (i_flags.fe_last) begin
                    n_state = S_E_END;
                end else begin
                    w_ctl.cmd = CMD_FRD_KP1; n_state = S_E_WR;
                end
            end
            S_E_WR: begin w_ctl.cmd = CMD_FWR_K_INC; n_state = S_E_RD; end
            S_E_END: begin
                w_ctl.cmd = CMD_FCNT_DEC;
                n_state   = i_flags.mode_free ? S_UE_INIT : S_OK;
            end
            // Used-table erase after a free.
            S_UE_INIT: begin w_ctl.cmd = CMD_UE_INIT; n_state = S_UE_RD; end
            S_UE_RD: begin
                if (i_flags.ue_last) begin
                    n_state = S_UE_END;
                end else begin
                    w_ctl.cmd = CMD_URD_KP1; n_state = S_UE_WR;
                end
            end
            S_UE_WR:  begin w_ctl.cmd = CMD_UWR_K_INC; n_state = S_UE_RD; end
            S_UE_END: begin w_ctl.cmd = CMD_UCNT_DEC;  n_state = S_OK;    end
            S_OK: begin
                w_ctl.cmd = CMD_RESULT; w_ctl.status = ST_OK; n_state = S_DONE;
            end
            S_DONE: begin
                if (i_flags.out_free) begin
                    w_ctl.cmd = CMD_OUT_LOAD; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_ctl      = w_ctl;
endmodule

FILE: hdl/ffsa_dp.sv
// Datapath of the segment allocator: table memories, indices, counters and result register.
// Depends on ffsa_pkg and ffsa_ram; executes one t_ctl command per cycle.
module ffsa_dp #(
    parameter int MAX_SEGMENTS = ffsa_pkg::DEFAULT_MAX_SEGMENTS,
    parameter int ADDR_WIDTH   = ffsa_pkg::DEFAULT_ADDR_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffsa_pkg::t_ctl                i_ctl,
    output ffsa_pkg::t_flags              o_flags,
    input  logic                          i_mode,
    input  logic [ffsa_pkg::SIZE_W-1:0]   i_size,
    input  logic [ffsa_pkg::FADDR_W-1:0]  i_addr,
    input  logic                          i_cfg_we,
    input  logic [ffsa_pkg::SIZE_W-1:0]   i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [ffsa_pkg::STAT_W-1:0]   o_status,
    output logic [ffsa_pkg::GRANT_W-1:0]  o_grant
);
    import ffsa_pkg::*;

    localparam int EW  = ADDR_WIDTH + 1;                 // start or length
    localparam int CW  = (EW > SIZE_W) ? EW : SIZE_W;    // compare width
    localparam int FIW = $clog2(MAX_SEGMENTS + 2);       // free index incl. entry 0
    localparam int UIW = $clog2(MAX_SEGMENTS + 1);
    localparam int RAW = $clog2(MAX_SEGMENTS);
    localparam logic [CW-1:0] LIMIT    = CW'(1) << ADDR_WIDTH;
    localparam logic [CW-1:0] RST_SIZE = (ADDR_WIDTH >= 16) ? CW'(65536) : LIMIT;
    localparam logic [FIW-1:0] FMAX    = FIW'(MAX_SEGMENTS + 1);
    localparam logic [UIW-1:0] UMAX    = UIW'(MAX_SEGMENTS);

    // Request and working registers.
    logic              r_mode;
    logic [SIZE_W-1:0] r_size;
    logic [FADDR_W-1:0] r_addr;
    logic [FIW-1:0]    r_i, r_b, r_k, r_fcnt;
    logic [UIW-1:0]    r_j, r_ucnt;
    logic [EW-1:0]     r_fs, r_fl, r_bs, r_bl, r_us, r_ul, r_loc, r_len0;
    logic              r_rd0;
    logic              r_ovalid;
    logic [STAT_W-1:0] r_ostatus;
    logic [GRANT_W-1:0] r_ogrant;
    logic [STAT_W-1:0] r_pstatus;
    logic [GRANT_W-1:0] r_pgrant;

    // Memory ports.
    logic [FIW-1:0]    w_fridx, w_fwidx, w_fridx_m1, w_fwidx_m1, w_a;
    logic              w_fwe;
    logic [EW-1:0]     w_fws, w_fwl;
    logic [FIW-1:0]    w_uridx, w_uwidx;
    logic              w_uwe;
    logic [EW-1:0]     w_uws, w_uwl;
    logic [2*EW-1:0]   w_fq, w_uq;
    logic [EW-1:0]     w_fe_s, w_fe_l, w_ue_s, w_ue_l, w_newlen;
    logic [CW-1:0]     w_loc, w_target, w_sat;

    assign w_a      = r_b + 1'b1;
    assign w_newlen = r_fl - EW'(r_size);
    assign w_loc    = CW'(r_fs) + CW'(r_fl) - CW'(r_size);

    // Entry 0 of the free table lives in a register and always starts at zero.
    assign w_fe_s = r_rd0 ? '0     : w_fq[2*EW-1:EW];
    assign w_fe_l = r_rd0 ? r_len0 : w_fq[EW-1:0];
    assign w_ue_s = w_uq[2*EW-1:EW];
    assign w_ue_l = w_uq[EW-1:0];

    // Memory address and write selection.
    always_comb begin
        w_fridx = r_i;
        w_fwidx = r_k;
        w_fwe   = 1'b0;
        w_fws   = w_fe_s;
        w_fwl   = w_fe_l;
        w_uridx = FIW'(r_j);
        w_uwidx = r_k;
        w_uwe   = 1'b0;
        w_uws   = w_ue_s;
        w_uwl   = w_ue_l;
        case (i_ctl.cmd)
            CMD_FRD_B:   w_fridx = r_b;
            CMD_FRD_A:   w_fridx = w_a;
            CMD_FRD_KP1: w_fridx = r_k + 1'b1;
            CMD_FRD_KM1: w_fridx = r_k - 1'b1;
            CMD_FSUB: begin
                w_fwe = 1'b1; w_fwidx = r_i; w_fws = r_fs; w_fwl = w_newlen;
            end
            CMD_FWR_K_INC, CMD_FWR_K_DEC: w_fwe = 1'b1;
            CMD_MERGE_BA: begin
                w_fwe = 1'b1; w_fwidx = r_b; w_fws = r_bs; w_fwl = r_bl + r_fl;
            end
            CMD_WR_A: begin
                w_fwe = 1'b1; w_fwidx = w_a; w_fws = r_fs; w_fwl = r_fl;
            end
            CMD_WR_B: begin
                w_fwe = 1'b1; w_fwidx = r_b; w_fws = r_bs; w_fwl = r_bl;
            end
            CMD_INS_NEW: begin
                w_fwe = 1'b1; w_fwidx = w_a; w_fws = r_us; w_fwl = r_ul;
            end
            CMD_URD_KM1: w_uridx = r_k - 1'b1;
            CMD_URD_KP1: w_uridx = r_k + 1'b1;
            CMD_UWR_K_DEC, CMD_UWR_K_INC: w_uwe = 1'b1;
            CMD_UWR_NEW: begin
                w_uwe = 1'b1; w_uwidx = FIW'(r_j); w_uws = r_loc; w_uwl = EW'(r_size);
            end
            default: ;
        endcase
    end

    assign w_fridx_m1 = w_fridx - 1'b1;
    assign w_fwidx_m1 = w_fwidx - 1'b1;

    // Free entries 1 and up; memory row n holds entry n+1.
    ffsa_ram #(.WIDTH(2*EW), .DEPTH(MAX_SEGMENTS)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (w_fwe && (w_fwidx != '0)),
        .i_waddr (w_fwidx_m1[RAW-1:0]),
        .i_wdata ({w_fws, w_fwl}),
        .i_raddr (w_fridx_m1[RAW-1:0]),
        .o_rdata (w_fq)
    );

    ffsa_ram #(.WIDTH(2*EW), .DEPTH(MAX_SEGMENTS)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (w_uwe),
        .i_waddr (w_uwidx[RAW-1:0]),
        .i_wdata ({w_uws, w_uwl}),
        .i_raddr (w_uridx[RAW-1:0]),
        .o_rdata (w_uq)
    );

    assign w_sat = (CW'(i_cfg_data) > LIMIT) ? LIMIT : CW'(i_cfg_data);

    // Table counters, entry-0 length and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len0   <= RST_SIZE[EW-1:0];
            r_fcnt   <= FIW'(1);
            r_ucnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len0 <= w_sat[EW-1:0];
                r_fcnt <= FIW'(1);
                r_ucnt <= '0;
            end else begin
                if (w_fwe && (w_fwidx == '0)) begin
                    r_len0 <= w_fwl;
                end
                case (i_ctl.cmd)
                    CMD_FCNT_DEC: r_fcnt <= r_fcnt - 1'b1;
                    CMD_INS_NEW:  r_fcnt <= r_fcnt + 1'b1;
                    CMD_UWR_NEW:  r_ucnt <= r_ucnt + 1'b1;
                    CMD_UCNT_DEC: r_ucnt <= r_ucnt - 1'b1;
                    default: ;
                endcase
            end
            if (i_ctl.cmd == CMD_OUT_LOAD) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Working registers of the current request. A finished result is held
    // aside until the output register is free to take it.
    always_ff @(posedge i_clk) begin
        r_rd0 <= (w_fridx == '0);
        case (i_ctl.cmd)
            CMD_LATCH: begin
                r_mode <= i_mode; r_size <= i_size; r_addr <= i_addr;
                r_i <= '0; r_j <= '0;
            end
            CMD_INC_I: r_i <= r_i + 1'b1;
            CMD_INC_J: r_j <= r_j + 1'b1;
            CMD_CAP_F: begin r_fs <= w_fe_s; r_fl <= w_fe_l; end
            CMD_CAP_B: begin r_bs <= w_fe_s; r_bl <= w_fe_l; end
            CMD_CAP_U: begin r_us <= w_ue_s; r_ul <= w_ue_l; end
            CMD_CALC_LOC: begin r_loc <= w_loc[EW-1:0]; r_k <= FIW'(r_ucnt); end
            CMD_UWR_K_DEC, CMD_FWR_K_DEC: r_k <= r_k - 1'b1;
            CMD_UWR_K_INC, CMD_FWR_K_INC: r_k <= r_k + 1'b1;
            CMD_FSUB:     begin r_fl <= w_newlen; r_k <= r_i; end
            CMD_SET_B:    r_b <= (r_i == '0) ? '0 : r_i - 1'b1;
            CMD_MERGE_A:  begin r_fs <= r_us; r_fl <= r_fl + r_ul; end
            CMD_GROW_B:   r_bl <= r_bl + r_ul;
            CMD_MERGE_BA: r_k <= w_a;
            CMD_INS_INIT: r_k <= r_fcnt;
            CMD_UE_INIT:  r_k <= FIW'(r_j);
            CMD_RESULT: begin
                r_pstatus <= i_ctl.status;
                r_pgrant  <= (i_ctl.status == ST_OK && r_mode != MODE_FREE)
                             ? GRANT_W'(r_loc[ADDR_WIDTH-1:0]) : '0;
            end
            CMD_OUT_LOAD: begin
                r_ostatus <= r_pstatus;
                r_ogrant  <= r_pgrant;
            end
            default: ;
        endcase
    end

    // Status flags for the controller.
    assign w_target = (r_mode == MODE_FREE) ? CW'(r_addr) : CW'(r_loc);

    always_comb begin
        o_flags.size_zero = (r_size == '0);
        o_flags.mode_free = (r_mode == MODE_FREE);
        o_flags.i_end     = (r_i == r_fcnt);
        o_flags.fit       = (CW'(w_fe_l) >= CW'(r_size));
        o_flags.u_full    = (r_ucnt == UMAX);
        o_flags.j_end     = (r_j == r_ucnt);
        o_flags.u_ge      = (CW'(w_ue_s) >= w_target);
        o_flags.u_eq      = (CW'(w_ue_s) == w_target);
        o_flags.f_ge      = (CW'(w_fe_s) >= CW'(r_addr));
        o_flags.k_eq_j    = (r_k == FIW'(r_j));
        o_flags.k_eq_a    = (r_k == w_a);
        o_flags.a_end     = (w_a == r_fcnt);
        o_flags.case_a    = (w_a != r_fcnt) && ((CW'(r_us) + CW'(r_ul)) == CW'(r_fs));
        o_flags.case_b    = ((CW'(r_bs) + CW'(r_bl)) == CW'(r_us));
        o_flags.adj_ba    = ((CW'(r_bs) + CW'(r_bl)) == CW'(r_fs));
        o_flags.f_room    = (r_fcnt < FMAX);
        o_flags.fe_last   = ((r_k + 1'b1) == r_fcnt);
        o_flags.ue_last   = ((r_k + 1'b1) == FIW'(r_ucnt));
        o_flags.fl_erase  = (r_i != '0) && (r_fl == '0);
        o_flags.out_free  = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_grant     = r_ogrant;
endmodule

FILE: hdl/first_fit_segment_allocator_top.sv
// Top level of the first-fit segment allocator.
// Depends on ffsa_pkg, ffsa_ctrl, ffsa_dp (and through it ffsa_ram).
//
// Usage
// -----
// Requests arrive on the s_axis channel: tuser carries the mode (0 allocate,
// 1 free), tdata carries request_size and free_address. Each request gives one
// result transfer on m_axis: tuser is the status code, tdata the granted address.
// The block takes one request at a time. The time a request takes grows with
// the table entries that it scans or shifts, because each table is a memory
// with one registered read port; scan plus shift touch each table at most
// once over its length. An allocate scans the free table, shifts the used
// table and may shift the free table once; a free scans both tables and may
// shift each of them once.
// A finished result sits in an output register, so the next request is taken
// while the receiver stalls; a second result waits in the datapath until the
// register drains. Reset gives one free segment of 65536 bytes (capped to the
// address space) and an empty used table; no clearing pass is needed. Writing
// the managed size through i_cfg_we reinitialises the tables the same way; the
// user must make it only while the block is idle; the block does not enforce it.
module first_fit_segment_allocator_top #(
    parameter int MAX_SEGMENTS = ffsa_pkg::DEFAULT_MAX_SEGMENTS,
    parameter int ADDR_WIDTH   = ffsa_pkg::DEFAULT_ADDR_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [16:0] request_size, [32:17] free_address
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] granted_address
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata     // managed space size in bytes
);
    import ffsa_pkg::*;

    t_ctl   w_ctl;
    t_flags w_flags;

    ffsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_flags    (w_flags),
        .o_ctl      (w_ctl)
    );

    ffsa_dp #(.MAX_SEGMENTS(MAX_SEGMENTS), .ADDR_WIDTH(ADDR_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .o_flags     (w_flags),
        .i_mode      (s_axis_tuser),
        .i_size      (s_axis_tdata[SIZE_W-1:0]),
        .i_addr      (s_axis_tdata[SIZE_W+FADDR_W-1:SIZE_W]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_wdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (m_axis_tuser),
        .o_grant     (m_axis_tdata)
    );

    // Only one request is in work: a transfer in closes the input next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request accepted while one is in work");

    // A failed or free request never reports an address.
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("address reported with a failing status");

    // A result is loaded only while the controller is busy, never from idle.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.cmd == CMD_OUT_LOAD) |-> !s_axis_tready)
        else $error("result loaded while idle");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");
endmodule

FILE: verif/first_fit_segment_allocator_checker.sv
// Checker for the first-fit segment allocator: predicts each result from the
// accepted requests and compares it with the result transfers.
// Depends on ffsa_pkg.
module first_fit_segment_allocator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);
    import ffsa_pkg::*;

    localparam int SEGS = DEFAULT_MAX_SEGMENTS;
    localparam int SPACE = 1 << DEFAULT_ADDR_WIDTH;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [GRANT_W-1:0] granted;
    } t_answer;

    int      seg_free_start [SEGS+1];
    int      seg_free_len   [SEGS+1];
    int      seg_free_cnt;
    int      seg_used_start [SEGS];
    int      seg_used_len   [SEGS];
    int      seg_used_cnt;
    t_answer answers_due[$];

    assign o_pending = answers_due.size();

    // Returns both tables to a single free segment of the given span, capped to the space, and an empty used table.
    function automatic void tables_clear(input int span);
        if (span > SPACE) span = SPACE;
        seg_free_start[0] = 0;
        seg_free_len[0]   = span;
        seg_free_cnt      = 1;
        seg_used_cnt      = 0;
    endfunction

    function automatic void free_remove(input int k);
        for (int n = k; n < seg_free_cnt - 1; n++) begin
            seg_free_start[n] = seg_free_start[n+1];
            seg_free_len[n]   = seg_free_len[n+1];
        end
        seg_free_cnt--;
    endfunction

    // Folds free entry a into entry b when the two touch.
    function automatic void join_free(input int b, input int a);
        if (a < seg_free_cnt && seg_free_start[b] + seg_free_len[b] == seg_free_start[a]) begin
            seg_free_len[b] += seg_free_len[a];
            free_remove(a);
        end
    endfunction

    function automatic t_answer carve_segment(input int want);
        t_answer r;
        int i, j, loc;
        r = '{ST_NOFIT, '0};
        if (want == 0) return r;
        for (i = 0; i < seg_free_cnt; i++)
            if (seg_free_len[i] >= want) break;
        if (i == seg_free_cnt) return r;
        if (seg_used_cnt >= SEGS) begin
            r.status = ST_UFULL;
            return r;
        end
        loc = seg_free_start[i] + seg_free_len[i] - want;
        for (j = 0; j < seg_used_cnt; j++)
            if (seg_used_start[j] >= loc) break;
        for (int n = seg_used_cnt; n > j; n--) begin
            seg_used_start[n] = seg_used_start[n-1];
            seg_used_len[n]   = seg_used_len[n-1];
        end
        seg_used_start[j] = loc;
        seg_used_len[j]   = want;
        seg_used_cnt++;
        seg_free_len[i] -= want;
        if (seg_free_len[i] == 0 && i != 0) free_remove(i);
        r.status  = ST_OK;
        r.granted = loc[GRANT_W-1:0];
        return r;
    endfunction

    function automatic t_answer release_segment(input int loc);
        t_answer r;
        int j, p, b, a, us, ul;
        r = '{ST_NOADDR, '0};
        for (j = 0; j < seg_used_cnt; j++)
            if (seg_used_start[j] >= loc) break;
        if (j == seg_used_cnt || seg_used_start[j] != loc) return r;
        us = seg_used_start[j];
        ul = seg_used_len[j];
        for (p = 0; p < seg_free_cnt; p++)
            if (seg_free_start[p] >= loc) break;
        b = (p == 0) ? 0 : p - 1;
        a = b + 1;
        if (a < seg_free_cnt && us + ul == seg_free_start[a]) begin
            seg_free_start[a] = us;
            seg_free_len[a]  += ul;
            join_free(b, a);
        end else if (seg_free_start[b] + seg_free_len[b] == us) begin
            seg_free_len[b] += ul;
            join_free(b, a);
        end else if (seg_free_cnt < SEGS + 1) begin
            for (int n = seg_free_cnt; n > a; n--) begin
                seg_free_start[n] = seg_free_start[n-1];
                seg_free_len[n]   = seg_free_len[n-1];
            end
            seg_free_start[a] = us;
            seg_free_len[a]   = ul;
            seg_free_cnt++;
        end
        for (int n = j; n < seg_used_cnt - 1; n++) begin
            seg_used_start[n] = seg_used_start[n+1];
            seg_used_len[n]   = seg_used_len[n+1];
        end
        seg_used_cnt--;
        r.status = ST_OK;
        return r;
    endfunction

    // Predict on accepted requests and compare on accepted results.
    always @(posedge i_clk) begin
        t_answer seen, due;
        if (!i_rst_n) begin
            tables_clear(SPACE);
            answers_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) tables_clear(int'(i_cfg_wdata));
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == MODE_FREE)
                    answers_due.push_back(release_segment(int'(s_axis_tdata[32:17])));
                else
                    answers_due.push_back(carve_segment(int'(s_axis_tdata[16:0])));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen = '{m_axis_tuser, m_axis_tdata};
                if (answers_due.size() == 0) begin
                    $error("result transfer with nothing expected: status %0d address %0d",
                           seen.status, seen.granted);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    due = answers_due.pop_front();
                    if (seen.status !== due.status) begin
                        $error("status: expected %0d, got %0d", due.status, seen.status);
                        o_fail_count <= o_fail_count + 1;
                    end else if (seen.granted !== due.granted) begin
                        $error("granted_address: expected %0d, got %0d",
                               due.granted, seen.granted);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/first_fit_segment_allocator_top_tb.sv
// Testbench top for the first-fit segment allocator: makes the request stimulus,
// the receiver stalls and the size writes, and gives the verdict.
// Depends on ffsa_pkg, first_fit_segment_allocator_top and its checker.
module first_fit_segment_allocator_top_tb;
    import ffsa_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [16:0] i_cfg_wdata = '0;
    int          fail_count;
    int          pending;
    int          calm_left = 0;      // cycles left with no idling on either side
    int          hold_left = 0;      // long receiver hold-off
    int          live_addr[$];       // nonzero addresses currently granted

    localparam logic MODE_ALLOC = 1'b0;

    first_fit_segment_allocator_top DUT (.*);

    first_fit_segment_allocator_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .m_axis_tuser, .i_cfg_we, .i_cfg_wdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver stalls at random, except during calm stretches, and once for long.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (calm_left > 0) || ($urandom_range(99) >= 14);
        end
        if (calm_left > 0) calm_left <= calm_left - 1;
    end

    // Offers one request and waits for its transfer; idles first at random.
    // Valid stays high from one request into the next unless the next one idles.
    task automatic send_request(input logic mode, input int want, input int addr);
        if (calm_left == 0 && $urandom_range(99) < 14) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 14);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {7'd0, addr[15:0], want[16:0]};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic set_size(input int span);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= span[16:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        live_addr.delete();
    endtask

    // Watches granted results so that random frees can aim at live segments.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready && m_axis_tuser == ST_OK && m_axis_tdata != 0)
            live_addr.push_back(int'(m_axis_tdata));
    end

    task automatic random_phase(input int count, input int span);
        int want, addr, k;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 55) begin
                case ($urandom_range(9))
                    0:       want = $urandom_range(131071);
                    1:       want = 0;
                    2, 3:    want = $urandom_range(span > 0 ? span : 1);
                    default: want = $urandom_range(1, (span / 48) + 1);
                endcase
                send_request(MODE_ALLOC, want, $urandom_range(65535));
            end else begin
                if (live_addr.size() > 0 && $urandom_range(9) < 8) begin
                    k    = $urandom_range(live_addr.size() - 1);
                    addr = live_addr[k];
                    live_addr.delete(k);
                end else begin
                    addr = $urandom_range(65535);
                end
                send_request(MODE_FREE, $urandom_range(131071), addr);
            end
        end
    endtask

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int spans[5];
        spans = '{17'h1FFFF, 65536, 1, 300, 5000};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed part: zero size, too large, exact fit, freeing, unknown address.
        send_request(MODE_ALLOC, 0, 0);
        send_request(MODE_ALLOC, 131071, 0);
        send_request(MODE_ALLOC, 65537, 0);
        send_request(MODE_ALLOC, 100, 65535);
        send_request(MODE_ALLOC, 200, 0);
        send_request(MODE_FREE, 0, 65436);
        send_request(MODE_FREE, 0, 65436);
        send_request(MODE_FREE, 131071, 65535);
        send_request(MODE_FREE, 0, 65236);
        send_request(MODE_ALLOC, 65536, 0);
        send_request(MODE_FREE, 0, 0);
        // Fill the used table, then one more allocate meets the full table.
        wait_drained();
        set_size(100);
        for (int n = 0; n < 65; n++) send_request(MODE_ALLOC, 1, 0);
        send_request(MODE_ALLOC, 50, 0);
        for (int n = 99; n >= 36; n -= 2) send_request(MODE_FREE, 0, n);
        // Receiver hold-off while requests keep coming.
        wait_drained();
        set_size(65536);
        hold_left = 400;
        random_phase(20, 65536);
        wait_drained();
        foreach (spans[s]) begin
            set_size(spans[s]);
            calm_left = (s == 1) ? 3000 : 0;
            random_phase(200, spans[s] > 65536 ? 65536 : spans[s]);
            wait_drained();
        end
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
